// File: hw/rtl/bsab_pkg.sv
// Shared types and constants of the bilinear scaled alpha blend block.
package bsab_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_BLEND_RATIO  = 3'd0,
        REG_SMALL_WIDTH  = 3'd1,
        REG_SMALL_HEIGHT = 3'd2,
        REG_LARGE_WIDTH  = 3'd3,
        REG_LARGE_HEIGHT = 3'd4,
        REG_X_STEP       = 3'd5,
        REG_Y_STEP       = 3'd6
    } reg_index_t;

    // Item kinds carried in tuser.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_BLEND = 1'b1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int POS_W      = 12;
    localparam int STEP_W     = 17;
    localparam int RATIO_W    = 9;
    localparam int SMALL_W    = 9;
    localparam int LARGE_W    = 13;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // One RGB pixel, blue in the low byte.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

endpackage

// File: hw/rtl/bilinear_scaled_alpha_blend.sv
// Alpha blend of a streamed large image with a stored small image upscaled by
// bilinear sampling. A word with tuser low loads one small-image pixel into the
// banked frame store and gives no result; a word with tuser high is blended
// and gives one result word. The block takes one word per cycle unless the
// output holds it back; the pipeline runs through an input register, the
// position multipliers, index clamping, the frame store read, the horizontal
// and vertical interpolation multipliers and the ratio multiplier. Loads and
// blends keep their order, so a blend sees every load accepted before it. Each
// stage holds while the stage after it is full and stalled, so bubbles close
// up under backpressure. The frame store has no clearing pass; pixels read
// before being loaded are undefined.
module bilinear_scaled_alpha_blend #(
    parameter int MAX_SMALL_WIDTH  = 256,
    parameter int MAX_SMALL_HEIGHT = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bsab_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bsab_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // column [11:0], row_index [23:12], blue_in [31:24], green_in [39:32],
    // red_in [47:40]
    input  logic [bsab_pkg::IN_DATA_W-1:0]     s_tdata,
    // action [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // blue_out [7:0], green_out [15:8], red_out [23:16]
    output logic [bsab_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import bsab_pkg::*;

    localparam int XW = (MAX_SMALL_WIDTH > 2) ? $clog2(MAX_SMALL_WIDTH) : 2;
    localparam int YW = (MAX_SMALL_HEIGHT > 2) ? $clog2(MAX_SMALL_HEIGHT) : 2;
    localparam int PW = POS_W + STEP_W;
    localparam logic [LARGE_W-1:0] MAXW = LARGE_W'(MAX_SMALL_WIDTH);
    localparam logic [LARGE_W-1:0] MAXH = LARGE_W'(MAX_SMALL_HEIGHT);

    // Configuration registers.
    logic [RATIO_W-1:0] blend_ratio_reg;
    logic [SMALL_W-1:0] small_width_reg, small_height_reg;
    logic [LARGE_W-1:0] large_width_reg, large_height_reg;
    logic [STEP_W-1:0]  x_step_reg, y_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_ratio_reg  <= RATIO_W'(128);
            small_width_reg  <= SMALL_W'(256);
            small_height_reg <= SMALL_W'(256);
            large_width_reg  <= LARGE_W'(256);
            large_height_reg <= LARGE_W'(256);
            x_step_reg       <= STEP_W'(65536);
            y_step_reg       <= STEP_W'(65536);
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_addr))
                REG_BLEND_RATIO:  blend_ratio_reg  <= cfg_wr_data[RATIO_W-1:0];
                REG_SMALL_WIDTH:  small_width_reg  <= cfg_wr_data[SMALL_W-1:0];
                REG_SMALL_HEIGHT: small_height_reg <= cfg_wr_data[SMALL_W-1:0];
                REG_LARGE_WIDTH:  large_width_reg  <= cfg_wr_data[LARGE_W-1:0];
                REG_LARGE_HEIGHT: large_height_reg <= cfg_wr_data[LARGE_W-1:0];
                REG_X_STEP:       x_step_reg       <= cfg_wr_data;
                REG_Y_STEP:       y_step_reg       <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and the ready chain from the output backwards.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, mv_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

    assign rdy_out  = !mv_reg || m_tready;
    assign rdy6     = !v6_reg || rdy_out;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    logic act3_reg, ok3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg <= s_tvalid;
            if (rdy2)    v2_reg <= v1_reg;
            if (rdy3)    v3_reg <= v2_reg;
            if (rdy4)    v4_reg <= v3_reg && act3_reg == ACT_BLEND;
            if (rdy5)    v5_reg <= v4_reg;
            if (rdy6)    v6_reg <= v5_reg;
            if (rdy_out) mv_reg <= v6_reg;
        end
    end

    // Stage 1: input register.
    logic               act1_reg;
    logic [POS_W-1:0]   col1_reg, row1_reg;
    pixel_t             pix1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            act1_reg <= s_tuser;
            col1_reg <= s_tdata[11:0];
            row1_reg <= s_tdata[23:12];
            pix1_reg <= s_tdata[47:24];
        end
    end

    // Stage 2: map the position into Q.16 small-image coordinates.
    logic               act2_reg;
    logic [POS_W-1:0]   col2_reg, row2_reg;
    logic [PW-1:0]      px2_reg, py2_reg;
    pixel_t             pix2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            act2_reg <= act1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            px2_reg  <= PW'(col1_reg) * PW'(x_step_reg);
            py2_reg  <= PW'(row1_reg) * PW'(y_step_reg);
            pix2_reg <= pix1_reg;
        end
    end

    // Effective sizes and clamped neighbor indexes.
    logic [LARGE_W-1:0] w_eff, h_eff, w_last, h_last, xr, yr, xa, xb, ya, yb;
    logic [RATIO_W-1:0] r_eff;
    logic [XW-1:0]      x1_next, x2_next;
    logic [YW-1:0]      y1_next, y2_next;
    logic               ok_next;

    always_comb begin
        if (small_width_reg == '0) begin
            w_eff = LARGE_W'(1);
        end else if (LARGE_W'(small_width_reg) > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = LARGE_W'(small_width_reg);
        end
        if (small_height_reg == '0) begin
            h_eff = LARGE_W'(1);
        end else if (LARGE_W'(small_height_reg) > MAXH) begin
            h_eff = MAXH;
        end else begin
            h_eff = LARGE_W'(small_height_reg);
        end
        w_last = w_eff - LARGE_W'(1);
        h_last = h_eff - LARGE_W'(1);
        xr = px2_reg[PW-1:16];
        yr = py2_reg[PW-1:16];
        xa = (xr > w_last) ? w_last : xr;
        ya = (yr > h_last) ? h_last : yr;
        xb = (xa == w_last) ? w_last : xa + LARGE_W'(1);
        yb = (ya == h_last) ? h_last : ya + LARGE_W'(1);
        r_eff = (blend_ratio_reg > RATIO_W'(256)) ? RATIO_W'(256) : blend_ratio_reg;
        ok_next = (LARGE_W'(col2_reg) < w_eff) && (LARGE_W'(row2_reg) < h_eff);
        // A load uses the first neighbor index as its write position.
        if (act2_reg == ACT_BLEND) begin
            x1_next = xa[XW-1:0];
            y1_next = ya[YW-1:0];
        end else begin
            x1_next = col2_reg[XW-1:0];
            y1_next = row2_reg[YW-1:0];
        end
        x2_next = xb[XW-1:0];
        y2_next = yb[YW-1:0];
    end

    // Stage 3: indexes and weights ready for the frame store.
    logic [XW-1:0]      x1_reg, x2_reg;
    logic [YW-1:0]      y1_reg, y2_reg;
    logic [15:0]        fx3_reg, fy3_reg;
    logic [RATIO_W-1:0] r3_reg;
    pixel_t             pix3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            act3_reg <= act2_reg;
            ok3_reg  <= ok_next;
            x1_reg   <= x1_next;
            x2_reg   <= x2_next;
            y1_reg   <= y1_next;
            y2_reg   <= y2_next;
            fx3_reg  <= px2_reg[15:0];
            fy3_reg  <= py2_reg[15:0];
            r3_reg   <= r_eff;
            pix3_reg <= pix2_reg;
        end
    end

    // Frame store access; loads write as they leave this stage.
    pixel_t p11, p21, p12, p22;

    bsab_frame_store #(
        .XW (XW),
        .YW (YW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (v3_reg && rdy4 && act3_reg == ACT_LOAD && ok3_reg),
        .wr_x    (x1_reg),
        .wr_y    (y1_reg),
        .wr_data (pix3_reg),
        .rd_en   (rdy4),
        .x1      (x1_reg),
        .x2      (x2_reg),
        .y1      (y1_reg),
        .y2      (y2_reg),
        .p11     (p11),
        .p21     (p21),
        .p12     (p12),
        .p22     (p22)
    );

    // Stage 4: weights travel beside the registered neighbor pixels.
    logic [15:0]        fx4_reg, fy4_reg;
    logic [RATIO_W-1:0] r4_reg;
    pixel_t             pix4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            fx4_reg  <= fx3_reg;
            fy4_reg  <= fy3_reg;
            r4_reg   <= r3_reg;
            pix4_reg <= pix3_reg;
        end
    end

    // Stage 5: horizontal interpolation, Q.16.
    logic [23:0]        top5_reg [3];
    logic [23:0]        bot5_reg [3];
    logic [15:0]        fy5_reg;
    logic [RATIO_W-1:0] r5_reg;
    pixel_t             pix5_reg;
    logic [23:0]        a11 [3], a21 [3], a12 [3], a22 [3];
    logic [16:0]        fx_inv;

    always_comb begin
        fx_inv = 17'h10000 - 17'(fx4_reg);
        a11[0] = 24'(p11.blue);  a11[1] = 24'(p11.green);  a11[2] = 24'(p11.red);
        a21[0] = 24'(p21.blue);  a21[1] = 24'(p21.green);  a21[2] = 24'(p21.red);
        a12[0] = 24'(p12.blue);  a12[1] = 24'(p12.green);  a12[2] = 24'(p12.red);
        a22[0] = 24'(p22.blue);  a22[1] = 24'(p22.green);  a22[2] = 24'(p22.red);
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            for (int k = 0; k < 3; k++) begin
                top5_reg[k] <= a11[k] * 24'(fx_inv) + a21[k] * 24'(fx4_reg);
                bot5_reg[k] <= a12[k] * 24'(fx_inv) + a22[k] * 24'(fx4_reg);
            end
            fy5_reg  <= fy4_reg;
            r5_reg   <= r4_reg;
            pix5_reg <= pix4_reg;
        end
    end

    // Stage 6: vertical interpolation, Q.32.
    logic [39:0]        s6_reg [3];
    logic [RATIO_W-1:0] r6_reg;
    pixel_t             pix6_reg;
    logic [16:0]        fy_inv;

    assign fy_inv = 17'h10000 - 17'(fy5_reg);

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            for (int k = 0; k < 3; k++) begin
                s6_reg[k] <= 40'(top5_reg[k]) * 40'(fy_inv)
                           + 40'(bot5_reg[k]) * 40'(fy5_reg);
            end
            r6_reg   <= r5_reg;
            pix6_reg <= pix5_reg;
        end
    end

    // Output stage: mix by the ratio in Q.40 and keep the integer byte.
    logic [47:0] t_val [3];
    logic [47:0] big   [3];
    logic [8:0]  r_inv;

    always_comb begin
        r_inv  = RATIO_W'(256) - r6_reg;
        big[0] = 48'(pix6_reg.blue);
        big[1] = 48'(pix6_reg.green);
        big[2] = 48'(pix6_reg.red);
        for (int k = 0; k < 3; k++) begin
            t_val[k] = ((big[k] * 48'(r6_reg)) << 32) + 48'(s6_reg[k]) * 48'(r_inv);
        end
    end

    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            m_tdata_reg <= {t_val[2][47:40], t_val[1][47:40], t_val[0][47:40]};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hw/rtl/bsab_frame_store.sv
// Small image store: four banks split by column and row parity, one write and
// four neighbor reads per cycle while rd_en is high, with registered read data.
module bsab_frame_store #(
    parameter int XW = 8,
    parameter int YW = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [XW-1:0]    wr_x,
    input  logic [YW-1:0]    wr_y,
    input  bsab_pkg::pixel_t wr_data,
    input  logic             rd_en,
    input  logic [XW-1:0]    x1,
    input  logic [XW-1:0]    x2,
    input  logic [YW-1:0]    y1,
    input  logic [YW-1:0]    y2,
    output bsab_pkg::pixel_t p11,
    output bsab_pkg::pixel_t p21,
    output bsab_pkg::pixel_t p12,
    output bsab_pkg::pixel_t p22
);
    import bsab_pkg::*;

    localparam int AW    = XW + YW - 2;
    localparam int DEPTH = 1 << AW;

    logic [XW-1:0] col_even, col_odd;
    logic [YW-1:0] row_even, row_odd;
    logic [AW-1:0] rd_addr [2][2];
    logic [AW-1:0] wr_addr;
    pixel_t        rd_reg  [2][2];
    logic          sx1_reg, sx2_reg, sy1_reg, sy2_reg;

    // Each neighbor pair holds one even and one odd index unless clamped.
    always_comb begin
        col_even = x1[0] ? x2 : x1;
        col_odd  = x1[0] ? x1 : x2;
        row_even = y1[0] ? y2 : y1;
        row_odd  = y1[0] ? y1 : y2;
        rd_addr[0][0] = {row_even[YW-1:1], col_even[XW-1:1]};
        rd_addr[0][1] = {row_even[YW-1:1], col_odd[XW-1:1]};
        rd_addr[1][0] = {row_odd[YW-1:1],  col_even[XW-1:1]};
        rd_addr[1][1] = {row_odd[YW-1:1],  col_odd[XW-1:1]};
        wr_addr       = {wr_y[YW-1:1], wr_x[XW-1:1]};
    end

    // Bank memories, indexed by row parity then column parity.
    for (genvar by = 0; by < 2; by++) begin : g_row
        for (genvar bx = 0; bx < 2; bx++) begin : g_col
            pixel_t mem [DEPTH];
            always_ff @(posedge aclk) begin
                if (wr_en && wr_y[0] == 1'(by) && wr_x[0] == 1'(bx)) begin
                    mem[wr_addr] <= wr_data;
                end
                if (rd_en) begin
                    rd_reg[by][bx] <= mem[rd_addr[by][bx]];
                end
            end
        end
    end

    // Parity of each neighbor, kept in step with the read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            sx1_reg <= x1[0];
            sx2_reg <= x2[0];
            sy1_reg <= y1[0];
            sy2_reg <= y2[0];
        end
    end

    assign p11 = rd_reg[sy1_reg][sx1_reg];
    assign p21 = rd_reg[sy1_reg][sx2_reg];
    assign p12 = rd_reg[sy2_reg][sx1_reg];
    assign p22 = rd_reg[sy2_reg][sx2_reg];

endmodule

// File: sim/tb.sv
// Self-checking testbench of the bilinear scaled alpha blend block.
`timescale 1ns / 100ps

module tb;
    import bsab_pkg::*;

    // Blend predictor and queue of expected blended pixels.
    class blend_scoreboard;
        logic [23:0] frame [int];
        int unsigned ratio, sw, sh, xs, ys;
        logic [23:0] pending [$];
        int errors;
        int blends;

        function void reset_regs();
            ratio = 128; sw = 256; sh = 256; xs = 65536; ys = 65536;
        endfunction

        function void write_reg(reg_index_t idx, int unsigned val);
            case (idx)
                REG_BLEND_RATIO:  ratio = val & 'h1FF;
                REG_SMALL_WIDTH:  sw = val & 'h1FF;
                REG_SMALL_HEIGHT: sh = val & 'h1FF;
                REG_X_STEP:       xs = val & 'h1FFFF;
                REG_Y_STEP:       ys = val & 'h1FFFF;
                default: ;
            endcase
        endfunction

        function int unsigned eff(int unsigned v);
            if (v == 0) return 1;
            if (v > 256) return 256;
            return v;
        endfunction

        function logic [23:0] pix(int unsigned x, int unsigned y);
            int a;
            a = y * 256 + x;
            if (frame.exists(a)) return frame[a];
            return '0;
        endfunction

        // Note one accepted word and predict its blended pixel, if any.
        function void note_word(logic act, logic [11:0] col, logic [11:0] row,
                                logic [23:0] big);
            int unsigned w, h, x1, x2, y1, y2, r;
            longint unsigned px, py, fx, fy, top, bot, s, t;
            logic [23:0] p11, p21, p12, p22, res;
            w = eff(sw);
            h = eff(sh);
            if (act == ACT_LOAD) begin
                if (col < w && row < h) frame[row * 256 + col] = big;
                return;
            end
            px = longint'(col) * xs;
            py = longint'(row) * ys;
            fx = px & 'hFFFF;
            fy = py & 'hFFFF;
            x1 = ((px >> 16) > w - 1) ? w - 1 : int'(px >> 16);
            x2 = (x1 + 1 > w - 1) ? w - 1 : x1 + 1;
            y1 = ((py >> 16) > h - 1) ? h - 1 : int'(py >> 16);
            y2 = (y1 + 1 > h - 1) ? h - 1 : y1 + 1;
            r = (ratio > 256) ? 256 : ratio;
            p11 = pix(x1, y1); p21 = pix(x2, y1);
            p12 = pix(x1, y2); p22 = pix(x2, y2);
            for (int k = 0; k < 3; k++) begin
                top = longint'(p11[8*k +: 8]) * (65536 - fx) + longint'(p21[8*k +: 8]) * fx;
                bot = longint'(p12[8*k +: 8]) * (65536 - fx) + longint'(p22[8*k +: 8]) * fx;
                s = top * (65536 - fy) + bot * fy;
                t = ((longint'(big[8*k +: 8]) * r) << 32) + s * (256 - r);
                res[8*k +: 8] = t[47:40];
            end
            pending.push_back(res);
        endfunction

        // Compare one result word with the oldest expectation.
        function void check_word(logic [23:0] got);
            logic [23:0] exp_px;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            blends++;
            if (got[7:0] !== exp_px[7:0]) begin
                $error("blue_out expected %0d actual %0d", exp_px[7:0], got[7:0]);
                errors++;
            end
            if (got[15:8] !== exp_px[15:8]) begin
                $error("green_out expected %0d actual %0d", exp_px[15:8], got[15:8]);
                errors++;
            end
            if (got[23:16] !== exp_px[23:16]) begin
                $error("red_out expected %0d actual %0d", exp_px[23:16], got[23:16]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    blend_scoreboard sb;
    int words_sent;
    bit stall_on = 1'b0;

    bilinear_scaled_alpha_blend dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sample results at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    // Receiver stall pattern: calm stretches, then periods of heavy stalling.
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
        m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // One register write; the write enable is low again when the task returns.
    task automatic write_reg(reg_index_t idx, int unsigned val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // Send one word and hold it until accepted; the next word is driven on the
    // same edge, so valid stays high within a burst.
    task automatic send_word(logic act, int unsigned col, int unsigned row,
                             logic [23:0] rgb);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {rgb, row[11:0], col[11:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(act, col[11:0], row[11:0], rgb);
        words_sent++;
        // Random gap between bursts.
        if ($urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // Load a whole small image so no blend reads an unwritten entry.
    task automatic load_image(int unsigned w, int unsigned h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_word(ACT_LOAD, x, y, 24'($urandom()));
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned lw,
                                int unsigned lh);
        write_reg(REG_SMALL_WIDTH, w);
        write_reg(REG_SMALL_HEIGHT, h);
        write_reg(REG_LARGE_WIDTH, lw);
        write_reg(REG_LARGE_HEIGHT, lh);
        write_reg(REG_X_STEP, (lw == 0) ? 65536 : (w * 65536) / lw);
        write_reg(REG_Y_STEP, (lh == 0) ? 65536 : (h * 65536) / lh);
    endtask

    task automatic random_blend(int unsigned lw, int unsigned lh);
        send_word(ACT_BLEND, $urandom_range(0, lw + lw / 4),
                  $urandom_range(0, lh + lh / 4), 24'($urandom()));
    endtask

    initial begin
        int unsigned w, h, lw, lh;
        sb = new();
        sb.reset_regs();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings on a 2x2 image loaded at the corners.
        write_reg(REG_SMALL_WIDTH, 2);
        write_reg(REG_SMALL_HEIGHT, 2);
        send_word(ACT_LOAD, 0, 0, 24'h000000);
        send_word(ACT_LOAD, 1, 0, 24'hFFFFFF);
        send_word(ACT_LOAD, 0, 1, 24'hFF00FF);
        send_word(ACT_LOAD, 1, 1, 24'h00FF00);
        // Loads outside the image are ignored.
        send_word(ACT_LOAD, 2, 0, 24'h123456);
        send_word(ACT_LOAD, 4095, 4095, 24'hABCDEF);
        send_word(ACT_BLEND, 0, 0, 24'hFFFFFF);
        send_word(ACT_BLEND, 1, 1, 24'h000000);
        send_word(ACT_BLEND, 4095, 4095, 24'hA5A55A);
        go_idle();
        // Half steps, all-small and all-large ratios, ratio above the maximum.
        write_reg(REG_X_STEP, 32768);
        write_reg(REG_Y_STEP, 32768);
        write_reg(REG_BLEND_RATIO, 0);
        send_word(ACT_BLEND, 1, 1, 24'hFFFFFF);
        send_word(ACT_BLEND, 3, 0, 24'h000000);
        go_idle();
        write_reg(REG_BLEND_RATIO, 256);
        send_word(ACT_BLEND, 1, 3, 24'h5A5A5A);
        go_idle();
        write_reg(REG_BLEND_RATIO, 511);
        write_reg(REG_X_STEP, 0);
        write_reg(REG_Y_STEP, 131071);
        send_word(ACT_BLEND, 4095, 1, 24'h00FF00);
        go_idle();
        // Zero and oversize small dimensions act as one and the maximum.
        write_reg(REG_BLEND_RATIO, 1);
        write_reg(REG_SMALL_WIDTH, 0);
        write_reg(REG_SMALL_HEIGHT, 511);
        write_reg(REG_X_STEP, 65535);
        write_reg(REG_Y_STEP, 1);
        send_word(ACT_BLEND, 4095, 0, 24'hFFFFFF);
        send_word(ACT_BLEND, 0, 4095, 24'h010203);
        go_idle();

        // Random phases: fresh geometry, full image load, then blends mixed with random loads.
        for (int ph = 0; ph < 8; ph++) begin
            w  = (ph == 7) ? 16 : $urandom_range(1, 8);
            h  = (ph == 6) ? 16 : $urandom_range(1, 8);
            lw = (ph == 5) ? 4096 : $urandom_range(1, 64);
            lh = (ph == 4) ? 4096 : $urandom_range(1, 64);
            write_reg(REG_BLEND_RATIO, (ph == 3) ? 256 : $urandom_range(0, 300));
            set_geometry(w, h, lw, lh);
            load_image(w, h);
            for (int i = 0; i < 15; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(ACT_LOAD, $urandom_range(0, 4095),
                              $urandom_range(0, 4095), 24'($urandom()));
                else
                    random_blend(lw, lh);
            end
            // Reload one pixel of the image mid-stream in every phase.
            send_word(ACT_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                      24'($urandom()));
            for (int i = 0; i < 5; i++) random_blend(lw, lh);
            go_idle();
        end

        $display("Sent %0d words and checked %0d blended pixels over many settings.",
                 words_sent, sb.blends);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** bilinear_scaled_alpha_blend: PASSED **");
        else
            $display("** bilinear_scaled_alpha_blend: FAILED **");
        $finish;
    end

    // Timeout.
    initial begin
        #5ms;
        $display("** bilinear_scaled_alpha_blend: FAILED **");
        $finish;
    end
endmodule
